### rtl/core/sled_pkg.sv
`default_nettype none

package sled_pkg;

    // Operation codes carried with each input beat.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_EOF   = 2'd2;

    // Digit base selector for numeric escapes.
    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    // Error codes reported on the result stream.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EOF_BODY   = 3'd1;
    localparam logic [2:0] ERR_EOF_ESC    = 3'd2;
    localparam logic [2:0] ERR_OCTAL      = 3'd3;
    localparam logic [2:0] ERR_CONTROL    = 3'd6;

    // Characters of interest.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_BODY   = 3'd1,
        M_ESC    = 3'd2,
        M_DIGITS = 3'd3,
        M_AFTER  = 3'd4,
        M_SLASH  = 3'd5,
        M_LINE   = 3'd6,
        M_BLOCK  = 3'd7
    } t_mode;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } t_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       literal_done;
        logic [1:0] pushback_count;
        logic       warn_no_newline;
        logic [2:0] error_code;
    } t_result;

    // Digit value: 0-9 for decimal digits, letters count from 10, anything
    // else gives a value above every base.
    function automatic logic [5:0] f_digit_value(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd63;
        if (c inside {[8'h30:8'h39]}) begin
            v = 6'(c - 8'h30);
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = 6'(c - 8'h61) + 6'd10;
        end else if (c inside {[8'h41:8'h5A]}) begin
            v = 6'(c - 8'h41) + 6'd10;
        end
        return v;
    endfunction

    // Control bytes that are never legal: 0, 11, 12, 14 to 31.
    function automatic logic f_is_bad_control(input logic [7:0] c);
        return (c inside {8'h00, 8'h0B, 8'h0C, [8'h0E:8'h1F]});
    endfunction

endpackage

`default_nettype wire

### rtl/core/string_literal_escape_decoder_top.sv
// Throughput: one input beat per cycle while the result stream does not stall;
// each source byte gives zero or one result. The input register and the result
// register each hold one beat, and the decode stage moves an item forward whenever
// the result register is free or drains. Reset (i_rst_n low, synchronous) empties
// both registers and returns the scanner to idle with all escape and comment state
// cleared.
`default_nettype none

module string_literal_escape_decoder_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input stream: one source byte per beat.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire  [1:0]  s_axis_tuser,   // [1:0] op
    // Result stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] pushback_count,
                                        // [10] warn_no_newline, [13:11] error_code,
                                        // [15:14] zero
    output logic        m_axis_tuser,   // [0] byte_valid
    output logic        m_axis_tlast    // literal_done
);

    sled_pkg::t_item   in_item;
    sled_pkg::t_item   stage_item;
    sled_pkg::t_result core_res;
    sled_pkg::t_result out_res;
    logic              stage_valid;
    logic              core_res_valid;
    logic              advance;

    assign in_item.op = s_axis_tuser;
    assign in_item.ch = s_axis_tdata;

    // The decode stage fires when it holds a beat and the result register can
    // take whatever it produces (beats that give no result pass through too).
    assign advance = stage_valid && (!m_axis_tvalid || m_axis_tready);

    sled_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // The scanner state machine updates only on the cycle its beat advances.
    sled_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (stage_item),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    sled_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_res_valid (core_res_valid),
        .i_res       (core_res),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.error_code, out_res.warn_no_newline,
                           out_res.pushback_count, out_res.data_byte};
    assign m_axis_tuser = out_res.byte_valid;
    assign m_axis_tlast = out_res.literal_done;

endmodule

`default_nettype wire

### rtl/core/sled_in_reg.sv
`default_nettype none

module sled_in_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  sled_pkg::t_item      i_item,
    input  wire                  i_advance,
    output logic                 o_valid,
    output sled_pkg::t_item      o_item
);

    logic            r_valid;
    sled_pkg::t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sled_core.sv
`default_nettype none

module sled_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  sled_pkg::t_item      i_item,
    output logic                 o_res_valid,
    output sled_pkg::t_result    o_res
);

    sled_pkg::t_mode r_mode,  n_mode;
    logic [7:0]      r_quote, n_quote;
    logic [7:0]      r_escv,  n_escv;
    logic [1:0]      r_base,  n_base;
    logic [1:0]      r_left,  n_left;
    logic            r_saw_nl, n_saw_nl;
    logic            r_star,  n_star;

    logic       active;
    logic       eof;
    logic       bad_ctl;
    logic [7:0] c_eff;
    logic [5:0] dval;
    logic [4:0] base_val;
    logic       digit_ok;
    logic [7:0] acc;
    logic [2:0] digit_err;
    logic       is_blank;

    assign active  = i_fire && (i_item.op == sled_pkg::OP_BYTE || i_item.op == sled_pkg::OP_EOF)
                     && (r_mode != sled_pkg::M_IDLE);
    assign eof     = (i_item.op == sled_pkg::OP_EOF);
    assign c_eff   = (i_item.ch inside {[8'h01:8'h08]}) ? sled_pkg::CH_LF : i_item.ch;
    assign bad_ctl = !eof && sled_pkg::f_is_bad_control(i_item.ch);
    assign is_blank = (c_eff == sled_pkg::CH_SPACE) || (c_eff == sled_pkg::CH_TAB)
                      || (c_eff == sled_pkg::CH_CR);

    // Numeric escape accumulation: one digit per byte, shift-add only.
    assign dval      = sled_pkg::f_digit_value(c_eff);
    assign digit_err = sled_pkg::ERR_OCTAL + {1'b0, r_base};
    always_comb begin
        case (r_base)
            sled_pkg::BASE_OCT: base_val = 5'd8;
            sled_pkg::BASE_DEC: base_val = 5'd10;
            default:            base_val = 5'd16;
        endcase
    end
    assign digit_ok = ({2'b00, dval[3:0]} == dval) && (dval[4:0] < base_val);

    always_comb begin
        case (r_base)
            sled_pkg::BASE_OCT: begin
                if (r_left == 2'd2) begin
                    acc = {r_escv[1:0], dval[2:0], 3'b000};
                end else begin
                    acc = r_escv + {5'd0, dval[2:0]};
                end
            end
            sled_pkg::BASE_DEC: acc = {r_escv[4:0], 3'b000} + {r_escv[6:0], 1'b0}
                                      + {4'd0, dval[3:0]};
            default:            acc = {r_escv[3:0], dval[3:0]};
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_mode   = r_mode;
        n_quote  = r_quote;
        n_escv   = r_escv;
        n_base   = r_base;
        n_left   = r_left;
        n_saw_nl = r_saw_nl;
        n_star   = r_star;
        if (i_fire && i_item.op == sled_pkg::OP_START) begin
            n_mode   = sled_pkg::M_BODY;
            n_quote  = i_item.ch;
            n_escv   = 8'd0;
            n_base   = 2'd0;
            n_left   = 2'd0;
            n_saw_nl = 1'b0;
            n_star   = 1'b0;
        end else if (active) begin
            if (bad_ctl) begin
                n_mode = sled_pkg::M_IDLE;
            end else begin
                case (r_mode)
                    sled_pkg::M_BODY: begin
                        if (eof) begin
                            n_mode = sled_pkg::M_IDLE;
                        end else if (c_eff == sled_pkg::CH_BSLASH) begin
                            n_mode = sled_pkg::M_ESC;
                        end else if (is_blank && c_eff != sled_pkg::CH_SPACE
                                     || c_eff == sled_pkg::CH_LF) begin
                            n_mode = r_mode;
                        end else if (c_eff == r_quote) begin
                            n_mode   = sled_pkg::M_AFTER;
                            n_saw_nl = 1'b0;
                            n_star   = 1'b0;
                        end
                    end
                    sled_pkg::M_ESC: begin
                        if (eof) begin
                            n_mode = sled_pkg::M_IDLE;
                        end else if (c_eff inside {8'h30, 8'h31, 8'h32, 8'h33}) begin
                            n_mode = sled_pkg::M_DIGITS;
                            n_escv = {6'd0, c_eff[1:0]};
                            n_base = sled_pkg::BASE_OCT;
                            n_left = 2'd2;
                        end else if (c_eff == 8'h64) begin
                            n_mode = sled_pkg::M_DIGITS;
                            n_escv = 8'd0;
                            n_base = sled_pkg::BASE_DEC;
                            n_left = 2'd2;
                        end else if (c_eff == 8'h78) begin
                            n_mode = sled_pkg::M_DIGITS;
                            n_escv = 8'd0;
                            n_base = sled_pkg::BASE_HEX;
                            n_left = 2'd2;
                        end else begin
                            n_mode = sled_pkg::M_BODY;
                        end
                    end
                    sled_pkg::M_DIGITS: begin
                        if (eof || !digit_ok) begin
                            n_mode = sled_pkg::M_IDLE;
                        end else begin
                            n_escv = acc;
                            if (r_left > 2'd1) begin
                                n_left = r_left - 2'd1;
                            end else begin
                                n_left = 2'd0;
                                n_mode = sled_pkg::M_BODY;
                            end
                        end
                    end
                    sled_pkg::M_AFTER: begin
                        if (eof) begin
                            n_mode = sled_pkg::M_IDLE;
                        end else if (is_blank) begin
                            n_mode = r_mode;
                        end else if (c_eff == sled_pkg::CH_LF) begin
                            n_saw_nl = 1'b1;
                        end else if (c_eff == r_quote) begin
                            n_mode   = sled_pkg::M_BODY;
                            n_saw_nl = 1'b0;
                        end else if (c_eff == sled_pkg::CH_SLASH) begin
                            n_mode = sled_pkg::M_SLASH;
                        end else begin
                            n_mode = sled_pkg::M_IDLE;
                        end
                    end
                    sled_pkg::M_SLASH: begin
                        if (eof) begin
                            n_mode = sled_pkg::M_IDLE;
                        end else if (c_eff == sled_pkg::CH_SLASH) begin
                            n_mode = sled_pkg::M_LINE;
                        end else if (c_eff == sled_pkg::CH_STAR) begin
                            n_mode = sled_pkg::M_BLOCK;
                            n_star = 1'b0;
                        end else begin
                            n_mode = sled_pkg::M_IDLE;
                        end
                    end
                    sled_pkg::M_LINE: begin
                        if (eof) begin
                            n_mode = sled_pkg::M_IDLE;
                        end else if (c_eff == sled_pkg::CH_LF) begin
                            n_mode = sled_pkg::M_AFTER;
                        end
                    end
                    sled_pkg::M_BLOCK: begin
                        if (eof) begin
                            n_mode = sled_pkg::M_IDLE;
                        end else if (r_star && c_eff == sled_pkg::CH_SLASH) begin
                            n_star = 1'b0;
                            n_mode = sled_pkg::M_AFTER;
                        end else begin
                            n_star = (c_eff == sled_pkg::CH_STAR);
                        end
                    end
                    default: n_mode = sled_pkg::M_IDLE;
                endcase
            end
        end
    end

    // Result logic.
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (active) begin
            if (bad_ctl) begin
                o_res_valid        = 1'b1;
                o_res.literal_done = 1'b1;
                o_res.error_code   = sled_pkg::ERR_CONTROL;
            end else begin
                case (r_mode)
                    sled_pkg::M_BODY: begin
                        if (eof) begin
                            o_res_valid        = 1'b1;
                            o_res.literal_done = 1'b1;
                            o_res.error_code   = sled_pkg::ERR_EOF_BODY;
                        end else if (c_eff != sled_pkg::CH_BSLASH
                                     && c_eff != sled_pkg::CH_LF
                                     && c_eff != sled_pkg::CH_CR
                                     && c_eff != sled_pkg::CH_TAB
                                     && c_eff != r_quote) begin
                            o_res_valid      = 1'b1;
                            o_res.data_byte  = c_eff;
                            o_res.byte_valid = 1'b1;
                        end
                    end
                    sled_pkg::M_ESC: begin
                        if (eof) begin
                            o_res_valid        = 1'b1;
                            o_res.literal_done = 1'b1;
                            o_res.error_code   = sled_pkg::ERR_EOF_ESC;
                        end else if (!(c_eff inside {8'h30, 8'h31, 8'h32, 8'h33,
                                                     8'h64, 8'h78})) begin
                            o_res_valid      = 1'b1;
                            o_res.byte_valid = 1'b1;
                            case (c_eff)
                                8'h61:   o_res.data_byte = 8'd7;
                                8'h62:   o_res.data_byte = 8'd8;
                                8'h63:   o_res.data_byte = 8'd0;
                                8'h66:   o_res.data_byte = 8'd12;
                                8'h6E:   o_res.data_byte = 8'd10;
                                8'h72:   o_res.data_byte = 8'd13;
                                8'h74:   o_res.data_byte = 8'd9;
                                8'h76:   o_res.data_byte = 8'd11;
                                default: o_res.data_byte = c_eff;
                            endcase
                        end
                    end
                    sled_pkg::M_DIGITS: begin
                        if (eof || !digit_ok) begin
                            o_res_valid        = 1'b1;
                            o_res.literal_done = 1'b1;
                            o_res.error_code   = digit_err;
                        end else if (r_left <= 2'd1) begin
                            o_res_valid      = 1'b1;
                            o_res.data_byte  = acc;
                            o_res.byte_valid = 1'b1;
                        end
                    end
                    sled_pkg::M_AFTER: begin
                        if (eof) begin
                            o_res_valid        = 1'b1;
                            o_res.literal_done = 1'b1;
                        end else if (is_blank || c_eff == sled_pkg::CH_LF
                                     || c_eff == sled_pkg::CH_SLASH && c_eff != r_quote) begin
                            o_res_valid = 1'b0;
                        end else if (c_eff == r_quote) begin
                            if (!r_saw_nl) begin
                                o_res_valid           = 1'b1;
                                o_res.warn_no_newline = 1'b1;
                            end
                        end else begin
                            o_res_valid          = 1'b1;
                            o_res.literal_done   = 1'b1;
                            o_res.pushback_count = 2'd1;
                        end
                    end
                    sled_pkg::M_SLASH: begin
                        if (eof) begin
                            o_res_valid          = 1'b1;
                            o_res.literal_done   = 1'b1;
                            o_res.pushback_count = 2'd1;
                        end else if (c_eff != sled_pkg::CH_SLASH
                                     && c_eff != sled_pkg::CH_STAR) begin
                            o_res_valid          = 1'b1;
                            o_res.literal_done   = 1'b1;
                            o_res.pushback_count = 2'd2;
                        end
                    end
                    sled_pkg::M_LINE, sled_pkg::M_BLOCK: begin
                        if (eof) begin
                            o_res_valid        = 1'b1;
                            o_res.literal_done = 1'b1;
                        end
                    end
                    default: o_res_valid = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sled_pkg::M_IDLE;
            r_quote  <= 8'd0;
            r_escv   <= 8'd0;
            r_base   <= 2'd0;
            r_left   <= 2'd0;
            r_saw_nl <= 1'b0;
            r_star   <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_quote  <= n_quote;
            r_escv   <= n_escv;
            r_base   <= n_base;
            r_left   <= n_left;
            r_saw_nl <= n_saw_nl;
            r_star   <= n_star;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sled_out_reg.sv
`default_nettype none

module sled_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_advance,
    input  wire                  i_res_valid,
    input  sled_pkg::t_result    i_res,
    input  wire                  i_ready,
    output logic                 o_valid,
    output sled_pkg::t_result    o_res
);

    logic              r_valid;
    sled_pkg::t_result r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sled_checker.sv
`default_nettype none

module sled_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [7:0]  s_axis_tdata,
    input wire [1:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // A decoded byte never ends the literal and carries no status.
    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            !m_axis_tlast && m_axis_tdata[13:8] == 6'd0)
        else $error("decoded byte carries status");

    // Any error ends the literal.
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13:11] != 3'd0 |-> m_axis_tlast)
        else $error("error without end of literal");

    // Pushback only on a clean end.
    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] != 2'd0 |->
            m_axis_tlast && m_axis_tdata[13:11] == 3'd0 && m_axis_tdata[9:8] != 2'd3)
        else $error("bad pushback report");

    // A warning result is bare: no byte, no end.
    a_warn_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |->
            !m_axis_tuser && !m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
        else $error("warning result carries data");

endmodule

bind string_literal_escape_decoder_top sled_checker u_sled_checker (.*);

`default_nettype wire

### bench/tb_string_literal_escape_decoder_top.sv
`default_nettype none

module tb_string_literal_escape_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves out.
    // The fourth op value is reserved and must be ignored in every mode.
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [2:0] ERR_DECIMAL = 3'd4;
    localparam logic [2:0] ERR_HEX     = 3'd5;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;

    // Clock, reset and the two streams. Every input starts at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] ch
    logic [1:0]  s_axis_tuser = 2'd0;     // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [7:0] data_byte, [9:8] pushback_count,
                                          // [10] warn_no_newline, [13:11] error_code,
                                          // [15:14] zero
    logic        m_axis_tuser;            // [0] byte_valid
    logic        m_axis_tlast;            // literal_done

    string_literal_escape_decoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 2 ns clock period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle rates in percent; the stimulus process changes them per phase.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatch_count = 0;
    int decoded_beats  = 0;   // accepted beats that the scanner actually acts on

    // Decoded results still owed by the block, oldest first.
    sled_pkg::t_result pending_decodes[$];

    // Shadow copy of the scanner state.
    sled_pkg::t_mode lit_mode  = sled_pkg::M_IDLE;
    logic [7:0]      lit_quote = 8'h00;
    logic [7:0]      esc_acc   = 8'h00;
    logic [1:0]      esc_base  = sled_pkg::BASE_OCT;
    logic [1:0]      esc_left  = 2'd0;
    logic            nl_seen   = 1'b0;
    logic            star_seen = 1'b0;

    string simple_letters = "abcfnrtv";

    // One row of the directed table. When typed is set, the row carries its own
    // expectation (has says whether a result beat is due at all).
    typedef struct packed {
        logic [1:0]        op;
        logic [7:0]        ch;
        logic              typed;
        logic              has;
        sled_pkg::t_result res;
    } t_dir_row;

    t_dir_row dir_rows[$];

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic sled_pkg::t_result result_of(input logic [7:0] data,
                                                    input logic valid,
                                                    input logic done,
                                                    input logic [1:0] push,
                                                    input logic warn,
                                                    input logic [2:0] err);
        sled_pkg::t_result r;
        r.data_byte       = data;
        r.byte_valid      = valid;
        r.literal_done    = done;
        r.pushback_count  = push;
        r.warn_no_newline = warn;
        r.error_code      = err;
        return r;
    endfunction

    // Digits 0-9 count as themselves; letters of either case count from 10.
    function automatic int char_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "z") return int'(c - "a") + 10;
        if (c >= "A" && c <= "Z") return int'(c - "A") + 10;
        return 99;
    endfunction

    // Predictor: advances the shadow scanner by one accepted beat and tells
    // whether a result beat follows, and what it holds.
    task automatic decode_beat(input logic [1:0] op, input logic [7:0] raw,
                               output logic got, output sled_pkg::t_result res);
        logic [7:0] c;
        logic [2:0] derr;
        int radix;
        int n;
        int acc;
        logic eof;
        got = 1'b0;
        res = '0;
        c = raw;
        if (op == sled_pkg::OP_START) begin
            // A start always opens a fresh literal, abandoning any in progress.
            lit_mode  = sled_pkg::M_BODY;
            lit_quote = raw;
            esc_acc   = 8'h00;
            esc_base  = sled_pkg::BASE_OCT;
            esc_left  = 2'd0;
            nl_seen   = 1'b0;
            star_seen = 1'b0;
            return;
        end
        if (op == OP_UNUSED || lit_mode == sled_pkg::M_IDLE) return;
        eof = (op == sled_pkg::OP_EOF);

        // Bytes 1 to 8 read as a newline; other stray control bytes are fatal.
        if (!eof) begin
            if (c >= 8'd1 && c <= 8'd8) begin
                c = sled_pkg::CH_LF;
            end else if (c < sled_pkg::CH_SPACE && c != sled_pkg::CH_TAB
                         && c != sled_pkg::CH_LF && c != sled_pkg::CH_CR) begin
                res = result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0, sled_pkg::ERR_CONTROL);
                got = 1'b1;
            end
        end

        if (!got) begin
            case (lit_mode)
                sled_pkg::M_BODY: begin
                    if (eof) begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0,
                                        sled_pkg::ERR_EOF_BODY);
                        got = 1'b1;
                    end else if (c == sled_pkg::CH_BSLASH) begin
                        lit_mode = sled_pkg::M_ESC;
                    end else if (c == sled_pkg::CH_LF || c == sled_pkg::CH_CR
                                 || c == sled_pkg::CH_TAB) begin
                        // Unescaped whitespace controls are dropped.
                    end else if (c == lit_quote) begin
                        lit_mode  = sled_pkg::M_AFTER;
                        nl_seen   = 1'b0;
                        star_seen = 1'b0;
                    end else begin
                        res = result_of(c, 1'b1, 1'b0, 2'd0, 1'b0, sled_pkg::ERR_NONE);
                        got = 1'b1;
                    end
                end
                sled_pkg::M_ESC: begin
                    if (eof) begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0,
                                        sled_pkg::ERR_EOF_ESC);
                        got = 1'b1;
                    end else begin
                        lit_mode = sled_pkg::M_BODY;
                        case (c)
                            "0", "1", "2", "3": begin
                                // The leading octal digit is kept as the top digit.
                                esc_acc  = c - "0";
                                esc_base = sled_pkg::BASE_OCT;
                                esc_left = 2'd2;
                                lit_mode = sled_pkg::M_DIGITS;
                            end
                            "d": begin
                                esc_acc  = 8'h00;
                                esc_base = sled_pkg::BASE_DEC;
                                esc_left = 2'd2;
                                lit_mode = sled_pkg::M_DIGITS;
                            end
                            "x": begin
                                esc_acc  = 8'h00;
                                esc_base = sled_pkg::BASE_HEX;
                                esc_left = 2'd2;
                                lit_mode = sled_pkg::M_DIGITS;
                            end
                            default: begin
                                case (c)
                                    "a": c = 8'h07;
                                    "b": c = 8'h08;
                                    "c": c = 8'h00;
                                    "f": c = 8'h0C;
                                    "n": c = 8'h0A;
                                    "r": c = 8'h0D;
                                    "t": c = 8'h09;
                                    "v": c = 8'h0B;
                                    default: ;
                                endcase
                                // Escaped bytes are data even when they match the quote.
                                res = result_of(c, 1'b1, 1'b0, 2'd0, 1'b0,
                                                sled_pkg::ERR_NONE);
                                got = 1'b1;
                            end
                        endcase
                    end
                end
                sled_pkg::M_DIGITS: begin
                    radix = (esc_base == sled_pkg::BASE_OCT) ? 8
                          : (esc_base == sled_pkg::BASE_DEC) ? 10 : 16;
                    derr  = 3'(int'(sled_pkg::ERR_OCTAL) + int'(esc_base));
                    n     = eof ? 99 : char_digit(c);
                    if (eof || n >= radix) begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0, derr);
                        got = 1'b1;
                    end else begin
                        if (esc_base == sled_pkg::BASE_OCT && esc_left == 2'd2) begin
                            acc = int'(esc_acc) * 64 + n * 8;
                        end else if (esc_base == sled_pkg::BASE_OCT) begin
                            acc = int'(esc_acc) + n;
                        end else begin
                            acc = int'(esc_acc) * radix + n;
                        end
                        esc_acc = 8'(acc);
                        if (esc_left > 2'd1) begin
                            esc_left = esc_left - 2'd1;
                        end else begin
                            esc_left = 2'd0;
                            lit_mode = sled_pkg::M_BODY;
                            res = result_of(esc_acc, 1'b1, 1'b0, 2'd0, 1'b0,
                                            sled_pkg::ERR_NONE);
                            got = 1'b1;
                        end
                    end
                end
                sled_pkg::M_AFTER: begin
                    // Order matters: blank, newline, quote, slash.
                    if (eof) begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0, sled_pkg::ERR_NONE);
                        got = 1'b1;
                    end else if (c == sled_pkg::CH_SPACE || c == sled_pkg::CH_TAB
                                 || c == sled_pkg::CH_CR) begin
                    end else if (c == sled_pkg::CH_LF) begin
                        nl_seen = 1'b1;
                    end else if (c == lit_quote) begin
                        lit_mode = sled_pkg::M_BODY;
                        if (!nl_seen) begin
                            res = result_of(8'h00, 1'b0, 1'b0, 2'd0, 1'b1,
                                            sled_pkg::ERR_NONE);
                            got = 1'b1;
                        end
                        nl_seen = 1'b0;
                    end else if (c == sled_pkg::CH_SLASH) begin
                        lit_mode = sled_pkg::M_SLASH;
                    end else begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd1, 1'b0, sled_pkg::ERR_NONE);
                        got = 1'b1;
                    end
                end
                sled_pkg::M_SLASH: begin
                    if (eof) begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd1, 1'b0, sled_pkg::ERR_NONE);
                        got = 1'b1;
                    end else if (c == sled_pkg::CH_SLASH) begin
                        lit_mode = sled_pkg::M_LINE;
                    end else if (c == sled_pkg::CH_STAR) begin
                        star_seen = 1'b0;
                        lit_mode  = sled_pkg::M_BLOCK;
                    end else begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd2, 1'b0, sled_pkg::ERR_NONE);
                        got = 1'b1;
                    end
                end
                sled_pkg::M_LINE: begin
                    if (eof) begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0, sled_pkg::ERR_NONE);
                        got = 1'b1;
                    end else if (c == sled_pkg::CH_LF) begin
                        lit_mode = sled_pkg::M_AFTER;
                    end
                end
                sled_pkg::M_BLOCK: begin
                    if (eof) begin
                        res = result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0, sled_pkg::ERR_NONE);
                        got = 1'b1;
                    end else if (star_seen && c == sled_pkg::CH_SLASH) begin
                        star_seen = 1'b0;
                        lit_mode  = sled_pkg::M_AFTER;
                    end else begin
                        star_seen = (c == sled_pkg::CH_STAR);
                    end
                end
                default: lit_mode = sled_pkg::M_IDLE;
            endcase
        end
        if (got && res.literal_done) lit_mode = sled_pkg::M_IDLE;
    endtask

    // Drives one input beat, with random idle cycles ahead of it, and waits for
    // the handshake. On acceptance the predictor runs and any result due is
    // queued, unless the caller supplied a typed expectation.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch,
                             input logic use_typed, input logic typed_has,
                             input sled_pkg::t_result typed_res);
        logic got;
        sled_pkg::t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tuser  <= 2'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == sled_pkg::OP_START
            || (op != OP_UNUSED && lit_mode != sled_pkg::M_IDLE)) decoded_beats++;
        decode_beat(op, ch, got, res);
        if (use_typed) begin
            got = typed_has;
            res = typed_res;
        end
        if (got) pending_decodes.push_back(res);
    endtask

    task automatic feed(input logic [1:0] op, input logic [7:0] ch);
        send_beat(op, ch, 1'b0, 1'b0, '0);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(126, 32));
    endfunction

    // A digit of the given radix in either letter case, now and then a wild byte.
    function automatic logic [7:0] pick_digit(input int radix);
        int v;
        if ($urandom_range(99) < 8) return 8'($urandom_range(255));
        v = $urandom_range(radix - 1);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    task automatic send_escape();
        int r;
        feed(sled_pkg::OP_BYTE, sled_pkg::CH_BSLASH);
        r = $urandom_range(99);
        if (r < 30) begin
            feed(sled_pkg::OP_BYTE, simple_letters[$urandom_range(7)]);
        end else if (r < 50) begin
            feed(sled_pkg::OP_BYTE, 8'("0" + $urandom_range(3)));
            repeat (2) feed(sled_pkg::OP_BYTE, pick_digit(8));
        end else if (r < 62) begin
            feed(sled_pkg::OP_BYTE, "d");
            repeat (2) feed(sled_pkg::OP_BYTE, pick_digit(10));
        end else if (r < 80) begin
            feed(sled_pkg::OP_BYTE, "x");
            repeat (2) feed(sled_pkg::OP_BYTE, pick_digit(16));
        end else begin
            feed(sled_pkg::OP_BYTE, 8'($urandom_range(255)));
        end
    endtask

    task automatic send_body_token();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            feed(sled_pkg::OP_BYTE, printable());
        end else if (r < 65) begin
            case ($urandom_range(3))
                0: feed(sled_pkg::OP_BYTE, sled_pkg::CH_TAB);
                1: feed(sled_pkg::OP_BYTE, sled_pkg::CH_LF);
                2: feed(sled_pkg::OP_BYTE, sled_pkg::CH_CR);
                default: feed(sled_pkg::OP_BYTE, 8'($urandom_range(8, 1)));
            endcase
        end else if (r < 90) begin
            send_escape();
        end else if (r < 95) begin
            feed(sled_pkg::OP_BYTE, 8'($urandom_range(255)));
        end else if (r < 97) begin
            feed(sled_pkg::OP_BYTE, 8'($urandom_range(31)));
        end else if (r < 98) begin
            feed(OP_UNUSED, 8'($urandom_range(255)));
        end else begin
            feed(sled_pkg::OP_EOF, 8'($urandom_range(255)));
        end
    endtask

    // Material that may sit between a closing quote and what follows it.
    task automatic send_after_quote();
        int r;
        repeat ($urandom_range(3)) begin
            r = $urandom_range(99);
            if (r < 30) begin
                case ($urandom_range(2))
                    0: feed(sled_pkg::OP_BYTE, sled_pkg::CH_SPACE);
                    1: feed(sled_pkg::OP_BYTE, sled_pkg::CH_TAB);
                    default: feed(sled_pkg::OP_BYTE, sled_pkg::CH_CR);
                endcase
            end else if (r < 55) begin
                feed(sled_pkg::OP_BYTE,
                     $urandom_range(1) ? sled_pkg::CH_LF : 8'($urandom_range(8, 1)));
            end else if (r < 75) begin
                feed(sled_pkg::OP_BYTE, sled_pkg::CH_SLASH);
                feed(sled_pkg::OP_BYTE, sled_pkg::CH_SLASH);
                repeat ($urandom_range(4)) feed(sled_pkg::OP_BYTE, printable());
                feed(sled_pkg::OP_BYTE,
                     $urandom_range(1) ? sled_pkg::CH_LF : 8'($urandom_range(8, 1)));
            end else if (r < 95) begin
                feed(sled_pkg::OP_BYTE, sled_pkg::CH_SLASH);
                feed(sled_pkg::OP_BYTE, sled_pkg::CH_STAR);
                repeat ($urandom_range(5)) begin
                    feed(sled_pkg::OP_BYTE,
                         $urandom_range(2) ? printable() : sled_pkg::CH_STAR);
                end
                feed(sled_pkg::OP_BYTE, sled_pkg::CH_STAR);
                feed(sled_pkg::OP_BYTE, sled_pkg::CH_SLASH);
            end else begin
                feed(sled_pkg::OP_BYTE, 8'($urandom_range(255)));
            end
        end
    endtask

    // A literal of one to three continued segments, then a random ending.
    task automatic send_literal();
        logic [7:0] q;
        int r;
        int segs;
        r = $urandom_range(99);
        q = (r < 45) ? CH_DQUOTE : (r < 80) ? CH_SQUOTE : 8'($urandom_range(255));
        feed(sled_pkg::OP_START, q);
        segs = $urandom_range(3, 1);
        for (int s = 0; s < segs; s++) begin
            repeat ($urandom_range(10)) send_body_token();
            feed(sled_pkg::OP_BYTE, q);
            send_after_quote();
            if (s < segs - 1) feed(sled_pkg::OP_BYTE, q);
        end
        r = $urandom_range(99);
        if (r < 40) begin
            feed(sled_pkg::OP_BYTE, printable());
        end else if (r < 55) begin
            feed(sled_pkg::OP_BYTE, sled_pkg::CH_SLASH);
            feed(sled_pkg::OP_BYTE, printable());
        end else if (r < 75) begin
            feed(sled_pkg::OP_EOF, 8'($urandom_range(255)));
        end else if (r < 85) begin
            feed(sled_pkg::OP_BYTE, sled_pkg::CH_SLASH);
            feed(sled_pkg::OP_EOF, 8'($urandom_range(255)));
        end else if (r < 92) begin
            // Left open: the next start abandons it.
        end else begin
            feed(sled_pkg::OP_BYTE, 8'($urandom_range(255)));
        end
    endtask

    function automatic t_dir_row step_row(input logic [1:0] op, input logic [7:0] ch);
        t_dir_row d;
        d = '0;
        d.op = op;
        d.ch = ch;
        return d;
    endfunction

    function automatic t_dir_row fixed_row(input logic [1:0] op, input logic [7:0] ch,
                                           input logic has, input sled_pkg::t_result res);
        t_dir_row d;
        d.op    = op;
        d.ch    = ch;
        d.typed = 1'b1;
        d.has   = has;
        d.res   = res;
        return d;
    endfunction

    // The receiver side: tready is redrawn every cycle at the current stall rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    // Every accepted result beat is matched against the oldest queued expectation.
    always @(posedge i_clk) begin : result_check
        sled_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_decodes.size() == 0) begin
                report_mismatch($sformatf(
                    "result beat with nothing pending: tdata %h user %b last %b",
                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                want = pending_decodes.pop_front();
                check_field("data_byte", m_axis_tdata[7:0], want.data_byte);
                check_field("byte_valid", m_axis_tuser, want.byte_valid);
                check_field("literal_done", m_axis_tlast, want.literal_done);
                check_field("pushback_count", m_axis_tdata[9:8], want.pushback_count);
                check_field("warn_no_newline", m_axis_tdata[10], want.warn_no_newline);
                check_field("error_code", m_axis_tdata[13:11], want.error_code);
                check_field("tdata pad", m_axis_tdata[15:14], 0);
            end
        end
    end

    // Stimulus: reset, the directed table, then four idle phases of random literals.
    initial begin : stimulus
        int phase_send[4];
        int phase_recv[4];
        int goal;
        int drain_cycles;
        phase_send = '{0, 54, 0, 16};
        phase_recv = '{0, 0, 54, 16};

        // Directed rows. Typed results are the ones obvious from the spec;
        // the rest go through the predictor.
        dir_rows.push_back(fixed_row(sled_pkg::OP_BYTE, "A", 1'b0, '0));   // ignored in idle
        dir_rows.push_back(step_row(sled_pkg::OP_START, CH_DQUOTE));
        dir_rows.push_back(fixed_row(OP_UNUSED, 8'hFF, 1'b0, '0));         // reserved op
        dir_rows.push_back(fixed_row(sled_pkg::OP_BYTE, 8'hFF, 1'b1,
                                     result_of(8'hFF, 1'b1, 1'b0, 2'd0, 1'b0,
                                               sled_pkg::ERR_NONE)));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, sled_pkg::CH_BSLASH)); // escaped quote
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, CH_DQUOTE));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, sled_pkg::CH_BSLASH)); // largest octal
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, "3"));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, "7"));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, "7"));
        dir_rows.push_back(step_row(sled_pkg::OP_START, CH_DQUOTE));       // start while active
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, sled_pkg::CH_BSLASH));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, "x"));
        dir_rows.push_back(fixed_row(sled_pkg::OP_BYTE, "g", 1'b1,         // letter past f
                                     result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0, ERR_HEX)));
        dir_rows.push_back(step_row(sled_pkg::OP_START, CH_DQUOTE));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, sled_pkg::CH_BSLASH));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, "d"));
        dir_rows.push_back(fixed_row(sled_pkg::OP_BYTE, "a", 1'b1,         // letter in decimal
                                     result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0, ERR_DECIMAL)));
        dir_rows.push_back(step_row(sled_pkg::OP_START, CH_DQUOTE));
        dir_rows.push_back(fixed_row(sled_pkg::OP_BYTE, 8'h00, 1'b1,
                                     result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0,
                                               sled_pkg::ERR_CONTROL)));
        dir_rows.push_back(step_row(sled_pkg::OP_START, CH_DQUOTE));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, CH_DQUOTE));
        dir_rows.push_back(fixed_row(sled_pkg::OP_BYTE, CH_DQUOTE, 1'b1,   // reopen, no newline
                                     result_of(8'h00, 1'b0, 1'b0, 2'd0, 1'b1,
                                               sled_pkg::ERR_NONE)));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, CH_DQUOTE));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, sled_pkg::CH_LF));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, CH_DQUOTE));        // reopen after newline
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, CH_DQUOTE));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, sled_pkg::CH_SLASH));
        dir_rows.push_back(fixed_row(sled_pkg::OP_BYTE, "q", 1'b1,         // lone slash pushed back
                                     result_of(8'h00, 1'b0, 1'b1, 2'd2, 1'b0,
                                               sled_pkg::ERR_NONE)));
        dir_rows.push_back(step_row(sled_pkg::OP_START, CH_SQUOTE));
        dir_rows.push_back(step_row(sled_pkg::OP_BYTE, sled_pkg::CH_BSLASH));
        dir_rows.push_back(fixed_row(sled_pkg::OP_EOF, 8'h00, 1'b1,
                                     result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0,
                                               sled_pkg::ERR_EOF_ESC)));
        dir_rows.push_back(step_row(sled_pkg::OP_START, CH_DQUOTE));
        dir_rows.push_back(fixed_row(sled_pkg::OP_EOF, 8'hFF, 1'b1,
                                     result_of(8'h00, 1'b0, 1'b1, 2'd0, 1'b0,
                                               sled_pkg::ERR_EOF_BODY)));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_beat(dir_rows[k].op, dir_rows[k].ch, dir_rows[k].typed,
                      dir_rows[k].has, dir_rows[k].res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            goal = decoded_beats + 400;
            while (decoded_beats < goal) begin
                if ($urandom_range(99) < 85) begin
                    send_literal();
                end else begin
                    repeat ($urandom_range(6, 1)) begin
                        feed(2'($urandom_range(3)), 8'($urandom_range(255)));
                    end
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Let the block drain, then keep watching to show any stray beat.
        drain_cycles = 0;
        while (pending_decodes.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_decodes.size() != 0) begin
            report_mismatch($sformatf("%0d expected result beats never arrived",
                                      pending_decodes.size()));
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial begin : run_limit
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
